/* rtl/core/length_prefixed_message_ring_assert.svh */
// Assertion macros for the length-prefixed message ring.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LPMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LPMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lpmr_pkg.sv */
// Package for the length-prefixed message ring: state type, action and status codes.
// No dependencies.
package lpmr_pkg;

    // Cells kept free so that full and empty differ
    localparam int unsigned QUEUE_SPACER = 1;

    localparam int unsigned ACT_W  = 3;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned LEN_W  = 11;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WR_OPEN  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WR_CLOSE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_OPEN  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CONSUME  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RD_CLOSE = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERREAD = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR_WR,
        ST_HDR_RD,
        ST_FINISH
    } state_t;

endpackage

/* rtl/core/length_prefixed_message_ring.sv */
// Length-prefixed message ring: top level with the byte memory and its sequencer.
// Depends on lpmr_pkg and length_prefixed_message_ring_assert.svh.
//
// Channel  Dir  Bits    Contents (lowest bit first)
// s_tuser  in   3       action
// s_tdata  in   8       write_data
// m_tuser  out  2       status
// m_tdata  out  24      read_data, message_ready, message_length, unread_skipped, pad
//
// One item at a time. Opens, appends, consumes and a read close that empties the ring
// skip the header states; a write close passes the header-write state and a read
// close that moves to the next message the header-read state: every header byte is
// one access of the single memory port. Reset is immediate, with no memory clearing
// pass. A stalled result sits in the output register while the next item is taken.
`include "length_prefixed_message_ring_assert.svh"

module length_prefixed_message_ring
    import lpmr_pkg::*;
#(
    parameter int unsigned RING_BYTES   = 1024,
    parameter int unsigned HEADER_BYTES = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] write_data
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_data, [8] message_ready,
                                   // [19:9] message_length, [20] unread_skipped
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int unsigned AW = $clog2(RING_BYTES);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned HW = 8 * HEADER_BYTES;
    localparam int unsigned KW = $clog2(HEADER_BYTES + 1);

    localparam logic [CW-1:0] RING_C  = CW'(RING_BYTES);
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] SPACE_C = CW'(RING_BYTES - QUEUE_SPACER);
    localparam logic [KW-1:0] K_LAST  = KW'(HEADER_BYTES - 1);
    localparam logic [KW-1:0] K_END   = KW'(HEADER_BYTES);
    localparam longint unsigned HDR_MAX = (HEADER_BYTES >= 4) ? 64'hFFFF_FFFF
                                        : ((64'd1 << (8 * HEADER_BYTES)) - 64'd1);

    // Offset into the ring, folded back once past the end
    function automatic logic [AW-1:0] ring_wrap(input logic [CW-1:0] sum);
        logic [CW-1:0] t;
        t = (sum >= RING_C) ? (sum - RING_C) : sum;
        return t[AW-1:0];
    endfunction

    // Registers
    state_t            state_reg, state_next;
    logic [AW-1:0]     wh_reg, wh_next;
    logic [AW-1:0]     rh_reg, rh_next;
    logic [CW-1:0]     built_reg, built_next;
    logic [CW-1:0]     consumed_reg, consumed_next;
    logic [CW-1:0]     len_reg, len_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              skip_reg, skip_next;
    logic              rdok_reg, rdok_next;
    logic [HW-1:0]     wbuf_reg, wbuf_next;
    logic [HW-1:0]     hdr_reg, hdr_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [7:0]        out_rdata_reg;
    logic              out_ready_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_skip_reg;

    // Ring memory, one port
    logic [7:0]    ring_mem [RING_BYTES];
    logic [7:0]    mem_q_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    // Derived values
    logic          accept;
    logic          empty;
    logic [CW-1:0] used;
    logic [CW-1:0] room;
    logic [CW-1:0] need;
    logic          hdr_full;
    logic [AW-1:0] next_msg_pos;
    logic [AW-1:0] consume_pos;
    logic [AW-1:0] close_rh;
    logic [AW-1:0] wr_hdr_pos;
    logic [AW-1:0] rd_hdr_pos;
    logic [HW-1:0] hdr_shift;
    logic          wr_last;
    logic          go_hdr_wr;
    logic          go_hdr_rd;
    logic          out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign empty    = (rh_reg == wh_reg);

    // Occupancy and free space, never wrapping below zero
    always_comb
    begin
        used = {1'b0, wh_reg} - {1'b0, rh_reg};
        if (wh_reg < rh_reg)
        begin
            used = used + RING_C;
        end
        room = SPACE_C - used;
    end

    assign need         = HDR_C + built_reg;
    assign hdr_full     = (64'(built_reg) >= HDR_MAX);
    assign next_msg_pos = ring_wrap({1'b0, wh_reg} + need);
    assign consume_pos  = ring_wrap({1'b0, rh_reg} + HDR_C + consumed_reg);
    assign close_rh     = ring_wrap({1'b0, rh_reg} + HDR_C + len_reg);
    assign wr_hdr_pos   = ring_wrap({1'b0, wh_reg} + CW'(k_reg));
    assign rd_hdr_pos   = ring_wrap({1'b0, rh_reg} + CW'(k_reg));
    assign hdr_shift    = HW'({mem_q_reg, hdr_reg} >> 8);
    assign wr_last      = (k_reg == K_LAST);
    assign out_load     = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (go_hdr_wr)
                        state_next = ST_HDR_WR;
                    else if (go_hdr_rd)
                        state_next = ST_HDR_RD;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_HDR_WR:
            begin
                if (wr_last)
                    state_next = ST_FINISH;
            end
            ST_HDR_RD:
            begin
                if (k_reg == K_END)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Action decode, head and count updates, memory port control
    always_comb
    begin
        wh_next       = wh_reg;
        rh_next       = rh_reg;
        built_next    = built_reg;
        consumed_next = consumed_reg;
        len_next      = len_reg;
        k_next        = k_reg;
        status_next   = status_reg;
        skip_next     = skip_reg;
        rdok_next     = rdok_reg;
        wbuf_next     = wbuf_reg;
        hdr_next      = hdr_reg;
        go_hdr_wr     = 1'b0;
        go_hdr_rd     = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = wr_hdr_pos;
        mem_wdata     = wbuf_reg[7:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    skip_next   = 1'b0;
                    rdok_next   = 1'b0;
                    k_next      = '0;
                    unique case (s_tuser)
                        ACT_WR_OPEN:
                        begin
                            if (room <= HDR_C)
                                status_next = STAT_FULL;
                            else
                                built_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (room <= need || hdr_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_addr   = next_msg_pos;
                                mem_wdata  = s_tdata;
                                built_next = built_reg + 1'b1;
                            end
                        end
                        ACT_WR_CLOSE:
                        begin
                            if (room < need)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wbuf_next = HW'(built_reg);
                                go_hdr_wr = 1'b1;
                            end
                        end
                        ACT_RD_OPEN:
                        begin
                            if (empty)
                                status_next = STAT_EMPTY;
                            else
                                consumed_next = '0;
                        end
                        ACT_CONSUME:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (consumed_reg >= len_reg)
                            begin
                                status_next = STAT_OVERREAD;
                            end
                            else
                            begin
                                mem_re        = 1'b1;
                                mem_addr      = consume_pos;
                                rdok_next     = 1'b1;
                                consumed_next = consumed_reg + 1'b1;
                            end
                        end
                        ACT_RD_CLOSE:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                skip_next     = (consumed_reg != len_reg);
                                rh_next       = close_rh;
                                consumed_next = '0;
                                if (close_rh == wh_reg)
                                    len_next = '0;
                                else
                                    go_hdr_rd = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Header out, low byte first, then commit
            ST_HDR_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = wr_hdr_pos;
                mem_wdata = wbuf_reg[7:0];
                wbuf_next = wbuf_reg >> 8;
                k_next    = k_reg + 1'b1;
                if (wr_last)
                begin
                    wh_next    = next_msg_pos;
                    built_next = '0;
                    if (empty)
                        len_next = built_reg;
                end
            end
            // Header of the next message in, one read ahead of the capture
            ST_HDR_RD:
            begin
                if (k_reg != K_END)
                begin
                    mem_re   = 1'b1;
                    mem_addr = rd_hdr_pos;
                    k_next   = k_reg + 1'b1;
                end
                if (k_reg != '0)
                    hdr_next = hdr_shift;
                if (k_reg == K_END)
                    len_next = CW'(hdr_shift);
            end
            ST_FINISH: ;
            default: ;
        endcase
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wh_reg        <= '0;
            rh_reg        <= '0;
            built_reg     <= '0;
            consumed_reg  <= '0;
            len_reg       <= '0;
            k_reg         <= '0;
            status_reg    <= STAT_OK;
            skip_reg      <= 1'b0;
            rdok_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wh_reg        <= wh_next;
            rh_reg        <= rh_next;
            built_reg     <= built_next;
            consumed_reg  <= consumed_next;
            len_reg       <= len_next;
            k_reg         <= k_next;
            status_reg    <= status_next;
            skip_reg      <= skip_next;
            rdok_reg      <= rdok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wbuf_reg <= wbuf_next;
        hdr_reg  <= hdr_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_rdata_reg  <= rdok_reg ? mem_q_reg : 8'd0;
            out_ready_reg  <= !empty;
            out_len_reg    <= empty ? '0 : LEN_W'(len_reg);
            out_skip_reg   <= skip_reg;
        end
    end

    // Ring memory, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= ring_mem[mem_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'd0, out_skip_reg, out_len_reg, out_ready_reg, out_rdata_reg};

    // Checks
    `LPMR_ASSERT_NOW(a_one_access, mem_we, !mem_re, "memory read and write in one cycle")
    `LPMR_ASSERT_NEXT(a_commit_nonempty, (state_reg == ST_HDR_WR) && wr_last, wh_reg != rh_reg, "commit left ring empty")
    `LPMR_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE, "sequencer idle after accept")
    `LPMR_ASSERT_NOW(a_hdr_count, state_reg == ST_HDR_RD, k_reg <= K_END, "header read count overrun")
    `LPMR_ASSERT_NOW(a_rdata_zero, out_valid_reg && (out_status_reg != STAT_OK), out_rdata_reg == 8'd0, "read data on failed action")

endmodule

/* test/tb_length_prefixed_message_ring.sv */
// Self-checking testbench for length_prefixed_message_ring: stream driver, monitor, scoreboard.
// Depends on lpmr_pkg and the RTL top level; predicts every result with its own ring model.
`timescale 1ns / 1ps

module tb_length_prefixed_message_ring;
    import lpmr_pkg::*;

    localparam int RING_BYTES   = 1024;
    localparam int HEADER_BYTES = 2;
    localparam int HEADER_MAX   = (1 << (8 * HEADER_BYTES)) - 1;

    // Codes the block treats as no-ops
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    // Two copies of the ring model: one steers stimulus, one predicts results
    localparam int PLAN_COPY  = 0;
    localparam int CHECK_COPY = 1;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 250;
    localparam int CALM_TAIL    = 80;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [7:0]        read_data;
        logic              ready;
        logic [LEN_W-1:0]  length;
        logic              skipped;
    } ring_result_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [7:0]       data;
        logic             sync;    // pause marker: wait until all results are back
    } ring_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] write_data
    logic [2:0]  s_tuser = 3'd0;    // [2:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] read_data, [8] message_ready,
                                    // [19:9] message_length, [20] unread_skipped
    logic [1:0]  m_tuser;           // [1:0] status

    // Ring model state, one row per copy
    logic [7:0] ring_mem [2][RING_BYTES];
    int wr_head  [2] = '{default: 0};
    int rd_head  [2] = '{default: 0};
    int built    [2] = '{default: 0};
    int consumed [2] = '{default: 0};

    ring_item_t   offered_items[$];
    ring_result_t expected_results[$];

    int plan_items   = 0;
    int total_items  = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int n_full = 0, n_empty = 0, n_overread = 0, n_skipped = 0, longest = 0;

    length_prefixed_message_ring #(
        .RING_BYTES  (RING_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Length in the header at the read head, zero when the ring is empty
    function automatic int head_length(input int m);
        int len;
        len = 0;
        if (rd_head[m] != wr_head[m])
        begin
            for (int k = 0; k < HEADER_BYTES; k++)
                len |= int'(ring_mem[m][(rd_head[m] + k) % RING_BYTES]) << (8 * k);
        end
        return len;
    endfunction

    // One action applied to a model copy; returns the result it must produce
    function automatic ring_result_t ring_predict(input int m, input logic [2:0] act,
                                                  input logic [7:0] data);
        ring_result_t r;
        int   room;
        int   len;
        logic empty;
        r = '0;
        r.status = STAT_OK;
        empty = (rd_head[m] == wr_head[m]);
        room = RING_BYTES - QUEUE_SPACER
             - ((wr_head[m] + RING_BYTES - rd_head[m]) % RING_BYTES);
        case (act)
            ACT_WR_OPEN:
            begin
                if (room <= HEADER_BYTES)
                    r.status = STAT_FULL;
                else
                    built[m] = 0;
            end
            ACT_APPEND:
            begin
                if (room <= HEADER_BYTES + built[m] || built[m] >= HEADER_MAX)
                    r.status = STAT_FULL;
                else
                begin
                    ring_mem[m][(wr_head[m] + HEADER_BYTES + built[m]) % RING_BYTES] = data;
                    built[m]++;
                end
            end
            ACT_WR_CLOSE:
            begin
                if (room < HEADER_BYTES + built[m])
                    r.status = STAT_FULL;
                else
                begin
                    // header low byte first, wrapping at the ring end
                    for (int k = 0; k < HEADER_BYTES; k++)
                        ring_mem[m][(wr_head[m] + k) % RING_BYTES] = 8'(built[m] >> (8 * k));
                    wr_head[m] = (wr_head[m] + HEADER_BYTES + built[m]) % RING_BYTES;
                    built[m] = 0;
                end
            end
            ACT_RD_OPEN:
            begin
                if (empty)
                    r.status = STAT_EMPTY;
                else
                    consumed[m] = 0;
            end
            ACT_CONSUME:
            begin
                if (empty)
                    r.status = STAT_EMPTY;
                else if (consumed[m] >= head_length(m))
                    r.status = STAT_OVERREAD;
                else
                begin
                    r.read_data =
                        ring_mem[m][(rd_head[m] + HEADER_BYTES + consumed[m]) % RING_BYTES];
                    consumed[m]++;
                end
            end
            ACT_RD_CLOSE:
            begin
                if (empty)
                    r.status = STAT_EMPTY;
                else
                begin
                    len = head_length(m);
                    r.skipped = (consumed[m] != len);
                    rd_head[m] = (rd_head[m] + HEADER_BYTES + len) % RING_BYTES;
                    consumed[m] = 0;
                end
            end
            default: ;
        endcase
        r.ready  = (rd_head[m] != wr_head[m]);
        r.length = LEN_W'(head_length(m));
        return r;
    endfunction

    // Queue one item for the driver and step the planning copy
    function automatic ring_result_t offer(input logic [2:0] act, input logic [7:0] data);
        offered_items.push_back('{act: act, data: data, sync: 1'b0});
        plan_items++;
        return ring_predict(PLAN_COPY, act, data);
    endfunction

    function automatic void mark_sync();
        offered_items.push_back('{act: ACT_WR_OPEN, data: 8'h00, sync: 1'b1});
    endfunction

    // Read out every committed message, consuming only a few bytes of each
    function automatic void gen_drain();
        while (rd_head[PLAN_COPY] != wr_head[PLAN_COPY])
        begin
            void'(offer(ACT_RD_OPEN, 8'($urandom_range(0, 255))));
            repeat ($urandom_range(0, 3))
                void'(offer(ACT_CONSUME, 8'($urandom_range(0, 255))));
            void'(offer(ACT_RD_CLOSE, 8'($urandom_range(0, 255))));
        end
    endfunction

    // Mostly well-formed write and read sequences, with broken ones and noise mixed in
    function automatic void gen_random_traffic(input int n);
        ring_result_t r;
        int target;
        int pick;
        int len;
        int reads;
        target = plan_items + n;
        while (plan_items < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick < 85 && rd_head[PLAN_COPY] == wr_head[PLAN_COPY]))
            begin
                pick = $urandom_range(0, 99);
                len = (pick < 70) ? $urandom_range(0, 8) :
                      (pick < 95) ? $urandom_range(9, 40) : $urandom_range(41, 120);
                if ($urandom_range(0, 9) != 0)
                    void'(offer(ACT_WR_OPEN, 8'($urandom_range(0, 255))));
                for (int i = 0; i < len; i++)
                begin
                    void'(offer(ACT_APPEND, 8'($urandom_range(0, 255))));
                    if ($urandom_range(0, 29) == 0)
                        void'(offer(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
                end
                void'(offer(ACT_WR_CLOSE, 8'($urandom_range(0, 255))));
            end
            else if (pick < 85)
            begin
                if ($urandom_range(0, 9) != 0)
                    r = offer(ACT_RD_OPEN, 8'($urandom_range(0, 255)));
                len = head_length(PLAN_COPY);
                pick = $urandom_range(0, 99);
                reads = (pick < 70) ? len :
                        (pick < 85) ? $urandom_range(0, len) : len + $urandom_range(1, 2);
                repeat (reads)
                    void'(offer(ACT_CONSUME, 8'($urandom_range(0, 255))));
                void'(offer(ACT_RD_CLOSE, 8'($urandom_range(0, 255))));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    void'(offer(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255))));
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    // Driver: s_tvalid/s_tuser/s_tdata, predicts at each accepted transfer
    int gap_left = 0;
    always @(posedge clk)
    begin
        logic       took;
        int         sent_now;
        logic       may_idle;
        ring_item_t nxt;
        if (rst_n)
        begin
            took = s_tvalid && s_tready;
            sent_now = items_sent;
            if (took)
            begin
                expected_results.push_back(ring_predict(CHECK_COPY, s_tuser, s_tdata));
                sent_now++;
                items_sent <= sent_now;
            end
            may_idle = (sent_now < total_items - CALM_TAIL) && ((sent_now % 256) < 180);
            if (!s_tvalid || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (may_idle && $urandom_range(0, 9) == 0)
                begin
                    gap_left = $urandom_range(1, 18) - 1;
                    s_tvalid <= 1'b0;
                end
                else if (offered_items.size() > 0 && offered_items[0].sync
                         && results_seen != sent_now)
                    s_tvalid <= 1'b0;
                else
                begin
                    if (offered_items.size() > 0 && offered_items[0].sync)
                        void'(offered_items.pop_front());
                    if (offered_items.size() > 0)
                    begin
                        nxt = offered_items.pop_front();
                        s_tuser  <= nxt.act;
                        s_tdata  <= nxt.data;
                        s_tvalid <= 1'b1;
                    end
                    else
                        s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transfer with the oldest prediction
    int   stall_left = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", {m_tuser, m_tdata}, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                    if (m_tdata[7:0] !== want.read_data)
                        report_mismatch("read_data", m_tdata[7:0], want.read_data);
                    if (m_tdata[8] !== want.ready)
                        report_mismatch("message_ready", m_tdata[8], want.ready);
                    if (m_tdata[19:9] !== want.length)
                        report_mismatch("message_length", m_tdata[19:9], want.length);
                    if (m_tdata[20] !== want.skipped)
                        report_mismatch("unread_skipped", m_tdata[20], want.skipped);
                    if (m_tdata[23:21] !== 3'b000)
                        report_mismatch("pad bits", m_tdata[23:21], 0);
                    n_full     += (want.status == STAT_FULL);
                    n_empty    += (want.status == STAT_EMPTY);
                    n_overread += (want.status == STAT_OVERREAD);
                    n_skipped  += want.skipped;
                    if (int'(want.length) > longest)
                        longest = want.length;
                end
            end
            // one long hold-off lets the block back up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 150)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (results_seen < total_items - CALM_TAIL && (results_seen % 256) > 60
                     && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either side
    int quiet = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        ring_result_t r;
        int   len;
        logic full_hit;

        // Directed: empty ring, byte extremes, over-read, skip, no-open paths, spare codes
        void'(offer(ACT_RD_OPEN, 8'h00));
        void'(offer(ACT_CONSUME, 8'hFF));
        void'(offer(ACT_RD_CLOSE, 8'h00));
        void'(offer(ACT_WR_OPEN, 8'h00));
        void'(offer(ACT_APPEND, 8'h00));
        void'(offer(ACT_APPEND, 8'hFF));
        void'(offer(ACT_WR_CLOSE, 8'h00));
        void'(offer(ACT_RD_OPEN, 8'h00));
        void'(offer(ACT_CONSUME, 8'h00));
        void'(offer(ACT_CONSUME, 8'h00));
        void'(offer(ACT_CONSUME, 8'h00));
        void'(offer(ACT_RD_CLOSE, 8'h00));
        void'(offer(ACT_WR_CLOSE, 8'h00));
        void'(offer(ACT_APPEND, 8'hA5));
        void'(offer(ACT_APPEND, 8'h5A));
        void'(offer(ACT_WR_CLOSE, 8'h00));
        void'(offer(ACT_SPARE6, 8'hFF));
        void'(offer(ACT_SPARE7, 8'h00));
        void'(offer(ACT_RD_OPEN, 8'h00));
        void'(offer(ACT_CONSUME, 8'h00));
        void'(offer(ACT_RD_CLOSE, 8'h00));
        void'(offer(ACT_CONSUME, 8'h00));
        void'(offer(ACT_RD_CLOSE, 8'h00));
        void'(offer(ACT_WR_OPEN, 8'h00));
        void'(offer(ACT_APPEND, 8'h3C));
        void'(offer(ACT_WR_OPEN, 8'h00));
        void'(offer(ACT_WR_CLOSE, 8'h00));
        mark_sync();

        gen_random_traffic(250);

        // Fill to capacity; the first message is sized so the next header
        // straddles the ring end
        gen_drain();
        len = (RING_BYTES - QUEUE_SPACER - HEADER_BYTES - wr_head[PLAN_COPY] + RING_BYTES)
              % RING_BYTES;
        if (len > RING_BYTES - QUEUE_SPACER - HEADER_BYTES)
            len = RING_BYTES - QUEUE_SPACER - HEADER_BYTES;
        full_hit = 1'b0;
        while (!full_hit)
        begin
            void'(offer(ACT_WR_OPEN, 8'($urandom_range(0, 255))));
            for (int i = 0; i < len && !full_hit; i++)
            begin
                r = offer(ACT_APPEND, 8'($urandom_range(0, 255)));
                if (r.status == STAT_FULL)
                    full_hit = 1'b1;
            end
            if (full_hit)
                void'(offer(ACT_APPEND, 8'($urandom_range(0, 255))));
            void'(offer(ACT_WR_CLOSE, 8'($urandom_range(0, 255))));
            len = $urandom_range(20, 300);
        end
        // no room left at all
        void'(offer(ACT_WR_OPEN, 8'h00));
        void'(offer(ACT_APPEND, 8'hFF));
        void'(offer(ACT_WR_CLOSE, 8'h00));
        gen_drain();
        void'(offer(ACT_RD_OPEN, 8'h00));
        void'(offer(ACT_CONSUME, 8'h00));
        mark_sync();

        gen_random_traffic(300);
        total_items = plan_items;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (items_sent < total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run: %0d items in, %0d results out; full %0d, empty %0d, over-read %0d,",
                 items_sent, results_seen, n_full, n_empty, n_overread);
        $display("  skipped closes %0d, longest header length %0d, one fill and drain.",
                 n_skipped, longest);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
